// File: src/itrd_pkg.sv
// Package for the integer to radix digits unit.
// Holds sizes, the radix limits, the controller/datapath command and status types
// and the digit to ASCII mapping. Depends on nothing.
package itrd_pkg;

    // Sizes of the input value and of the digit stack.
    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 31;

    // Radix register and digit values.
    localparam int RADIX_W = 6;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    // Long division: quotient bits resolved per cycle and cycles per digit.
    localparam int STEPS_PER_CYCLE = 8;
    localparam int DIV_CYCLES      = (VALUE_BITS + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
    localparam int DIV_BITS        = DIV_CYCLES * STEPS_PER_CYCLE;
    localparam int CNT_W           = $clog2(DIV_CYCLES + 1);

    // Stack addressing: the depth counter can hold MAX_DIGITS itself.
    localparam int IDX_W   = $clog2(MAX_DIGITS);
    localparam int DEPTH_W = $clog2(MAX_DIGITS + 1);

    // ASCII mapping.
    localparam int CHAR_W = 7;
    localparam logic [RADIX_W-1:0] LAST_DECIMAL = RADIX_W'(9);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ALPHA_OFFSET = CHAR_W'(87);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take a new value, clear the stack
        logic step;      // run one cycle of the long division
        logic push;      // last division cycle: push the remainder, keep the quotient
        logic pop;       // move the top digit into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_zero;    // quotient of the current division cycle is zero
        logic full;      // the push now in progress fills the stack
        logic last_pop;  // one digit left on the stack
        logic out_free;  // output register can take a beat this cycle
    } t_dp_sts;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d > LAST_DECIMAL) begin
            return dx + ALPHA_OFFSET;
        end
        return dx + ASCII_ZERO;
    endfunction

endpackage

// File: src/itrd_ctrl.sv
// Controller state machine of the integer to radix digits unit.
// Sequences load, division cycles and stack pops. Depends on itrd_pkg.
module itrd_ctrl
    import itrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POP
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_last_cycle;

    assign w_last_cycle = (r_cnt == CNT_W'(DIV_CYCLES - 1));
    assign o_busy       = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (w_last_cycle) begin
                    o_cmd.push = 1'b1;
                    n_cnt      = '0;
                    if (i_sts.q_zero || i_sts.full) begin
                        n_state = ST_POP;
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.last_pop) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: src/itrd_datapath.sv
// Datapath of the integer to radix digits unit: radix register, long divider,
// digit stack and output register. Depends on itrd_pkg.
module itrd_datapath
    import itrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [RADIX_W-1:0]    i_cfg_data,
    input  logic [VALUE_BITS-1:0] i_value,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [CHAR_W-1:0]     o_digit_char,
    output logic                  o_last_digit
);

    logic [RADIX_W-1:0]  r_radix;
    logic [DIV_BITS-1:0] r_work;
    logic [RADIX_W-1:0]  r_rem;
    logic [DEPTH_W-1:0]  r_depth;
    logic [RADIX_W-1:0]  r_stack [MAX_DIGITS];
    logic                r_o_valid;
    logic [CHAR_W-1:0]   r_o_char;
    logic                r_o_last;

    logic [DIV_BITS-1:0] w_work;
    logic [RADIX_W-1:0]  w_rem;
    logic [RADIX_W:0]    w_trial;
    logic [DEPTH_W-1:0]  w_top;
    logic [IDX_W-1:0]    w_wr_idx;
    logic [IDX_W-1:0]    w_rd_idx;

    // Eight restoring division steps on the narrow remainder. The dividend
    // bits leave the top of the work word and the quotient bits enter below.
    always_comb begin
        w_work  = r_work;
        w_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
            w_trial = {w_rem, w_work[DIV_BITS-1]};
            w_work  = {w_work[DIV_BITS-2:0], 1'b0};
            if (w_trial >= {1'b0, r_radix}) begin
                w_trial   = w_trial - {1'b0, r_radix};
                w_work[0] = 1'b1;
            end
            w_rem = w_trial[RADIX_W-1:0];
        end
    end

    assign w_top    = r_depth - DEPTH_W'(1);
    assign w_wr_idx = r_depth[IDX_W-1:0];
    assign w_rd_idx = w_top[IDX_W-1:0];

    assign o_sts.q_zero   = (w_work == '0);
    assign o_sts.full     = (r_depth == DEPTH_W'(MAX_DIGITS - 1));
    assign o_sts.last_pop = (r_depth == DEPTH_W'(1));
    assign o_sts.out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix   <= RADIX_RESET;
            r_depth   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_data >= RADIX_MIN) && (i_cfg_data <= RADIX_MAX)) begin
                r_radix <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_depth <= '0;
            end else if (i_cmd.push) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end else if (i_cmd.pop) begin
                r_depth <= w_top;
            end
            if (i_cmd.pop) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work <= DIV_BITS'(i_value);
            r_rem  <= '0;
        end else if (i_cmd.push) begin
            r_work <= w_work;
            r_rem  <= '0;
        end else if (i_cmd.step) begin
            r_work <= w_work;
            r_rem  <= w_rem;
        end
        if (i_cmd.push) begin
            r_stack[w_wr_idx] <= w_rem;
        end
        if (i_cmd.pop) begin
            r_o_char <= digit_to_ascii(r_stack[w_rd_idx]);
            r_o_last <= (r_depth == DEPTH_W'(1));
        end
    end

    assign o_valid      = r_o_valid;
    assign o_digit_char = r_o_char;
    assign o_last_digit = r_o_last;

endmodule

// File: src/integer_to_radix_digits_unit.sv
// Integer to radix digits unit: top level joining controller and datapath.
// Division runs 8 quotient bits per cycle over a 32-bit work word, then one
// beat per cycle leaves the digit stack while the output is not stalled. A new
// item is taken only after the last digit of the previous one has been popped.
// Reset (synchronous, active low) sets radix to 10 and empties the pipeline.
module integer_to_radix_digits_unit
    import itrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: radix register, writes outside 2..36 are dropped.
    input  logic                  i_cfg_we,
    input  logic [RADIX_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    // Output channel: one beat per digit, most significant first.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAR_W-1:0]     o_digit_char,
    output logic                  o_last_digit
);

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;
    logic    s_busy;

    // The controller walks through three phases: idle, where a beat is taken
    // whenever one is offered; division, where each digit is found by the long
    // divider and pushed onto the stack least significant first; and pop,
    // where digits leave most significant first as the output register frees.
    itrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd),
        .o_busy  (s_busy)
    );

    // The datapath owns the radix register, the divider, the stack and the
    // output register. The output register lets the next input beat be taken
    // while the final digit of the previous item still waits downstream.
    itrd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_value      (i_value),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // Only one item is in work at a time.
    assign o_stall = s_busy;

    // An accepted beat always starts the division phase.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("accepted beat did not start work");

    // A pop never overwrites a beat that is still stalled at the output.
    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.pop |-> s_sts.out_free)
        else $error("pop issued while output register held");

    // A pop always drives a new beat on the output next cycle.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.pop |=> o_valid)
        else $error("pop did not produce an output beat");

    // The final digit of an item leaves the controller idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.pop && s_sts.last_pop) |=> !o_stall)
        else $error("controller busy after final digit");

endmodule
